FILE: sv/assert_macros.svh
// Assertion helpers; the including module must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define MSV_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("msv checker: property failed");

// Checked at every edge, reset included.
`define MSV_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("msv checker: property failed");

`endif

FILE: sv/msv_pkg.sv
`timescale 1ns / 1ps

package msv_pkg;

  // Parse position inside the SUBSCRIBE body.
  typedef enum logic [5:0] {
    PH_ID_HI  = 6'b000001,
    PH_ID_LO  = 6'b000010,
    PH_LEN_HI = 6'b000100,
    PH_LEN_LO = 6'b001000,
    PH_FILTER = 6'b010000,
    PH_QOS    = 6'b100000
  } phase_t;

  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_FLAGS   = 4'd1;
  localparam logic [3:0] ST_SHORT   = 4'd2;
  localparam logic [3:0] ST_ZERO_ID = 4'd3;
  localparam logic [3:0] ST_NO_FILT = 4'd4;
  localparam logic [3:0] ST_TRUNC   = 4'd5;
  localparam logic [3:0] ST_EMPTY   = 4'd6;
  localparam logic [3:0] ST_NO_QOS  = 4'd7;
  localparam logic [3:0] ST_BAD_QOS = 4'd8;

  localparam logic [3:0] SUBSCRIBE_FLAGS = 4'h2;
  localparam logic [7:0] QOS_MAX         = 8'd2;

  localparam logic KIND_FILTER  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic [3:0] header_flags;
    logic       first_byte;
    logic       last_byte;
    logic       has_data;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  status;
    logic [15:0] packet_id;
    logic [15:0] filter_count;
    logic [15:0] filter_length;
    logic [1:0]  max_qos;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic a;
    logic b;
  } push_t;

endpackage

FILE: sv/msv_in_reg.sv
`timescale 1ns / 1ps

module msv_in_reg import msv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

FILE: sv/msv_core.sv
`timescale 1ns / 1ps

module msv_core import msv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  item_t item,
  output push_t push,
  output res_t  res_a,
  output res_t  res_b
);

  phase_t      phase, phase_next;
  logic [3:0]  error_code, error_code_next;
  logic [7:0]  id_high_byte, id_high_byte_next;
  logic [15:0] packet_ident, packet_ident_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] cur_len, cur_len_next;
  logic [15:0] filters_seen, filters_seen_next;

  phase_t      ph_w;
  logic [3:0]  err_w;
  logic [7:0]  idh_w;
  logic [15:0] pid_w;
  logic [15:0] left_w;
  logic [15:0] len_w;
  logic [15:0] cnt_w;
  logic        filter_done;
  logic [3:0]  verdict;
  res_t        res_f;
  res_t        res_v;

  always_comb begin
    ph_w        = phase;
    err_w       = error_code;
    idh_w       = id_high_byte;
    pid_w       = packet_ident;
    left_w      = bytes_left;
    len_w       = cur_len;
    cnt_w       = filters_seen;
    filter_done = 1'b0;

    // A first beat restarts the packet and drops whatever was in progress.
    if (item.first_byte) begin
      ph_w   = PH_ID_HI;
      err_w  = (item.header_flags != SUBSCRIBE_FLAGS) ? ST_FLAGS : ST_OK;
      idh_w  = 8'h00;
      pid_w  = 16'h0000;
      left_w = 16'h0000;
      len_w  = 16'h0000;
      cnt_w  = 16'h0000;
    end

    if (item.has_data && err_w == ST_OK) begin
      case (ph_w)
        PH_ID_HI: begin
          idh_w = item.data_byte;
          ph_w  = PH_ID_LO;
        end
        PH_ID_LO: begin
          pid_w = {idh_w, item.data_byte};
          if (pid_w == 16'h0000) begin
            err_w = ST_ZERO_ID;
          end
          ph_w = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_w = {item.data_byte, 8'h00};
          ph_w  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_w = len_w | {8'h00, item.data_byte};
          if (len_w == 16'h0000) begin
            err_w = ST_EMPTY;
          end else begin
            left_w = len_w;
            ph_w   = PH_FILTER;
          end
        end
        PH_FILTER: begin
          left_w = left_w - 16'd1;
          if (left_w == 16'h0000) begin
            ph_w = PH_QOS;
          end
        end
        PH_QOS: begin
          if (item.data_byte > QOS_MAX) begin
            err_w = ST_BAD_QOS;
          end else begin
            if (cnt_w != 16'hFFFF) begin
              cnt_w = cnt_w + 16'd1;
            end
            filter_done = 1'b1;
            ph_w        = PH_LEN_HI;
          end
        end
        default: ph_w = PH_ID_HI;
      endcase
    end

    if (err_w != ST_OK) begin
      verdict = err_w;
    end else begin
      case (ph_w)
        PH_ID_HI, PH_ID_LO:  verdict = ST_SHORT;
        PH_LEN_HI:           verdict = (cnt_w == 16'h0000) ? ST_NO_FILT : ST_OK;
        PH_LEN_LO, PH_FILTER: verdict = ST_TRUNC;
        PH_QOS:              verdict = ST_NO_QOS;
        default:             verdict = ST_TRUNC;
      endcase
    end

    res_f = '{result_kind:   KIND_FILTER,
              status:        ST_OK,
              packet_id:     pid_w,
              filter_count:  cnt_w,
              filter_length: len_w,
              max_qos:       item.data_byte[1:0],
              last_result:   !item.last_byte};
    res_v = '{result_kind:   KIND_VERDICT,
              status:        verdict,
              packet_id:     pid_w,
              filter_count:  cnt_w,
              filter_length: 16'h0000,
              max_qos:       2'b00,
              last_result:   1'b1};

    // Filter report goes ahead of the verdict when both fall on one beat.
    push.a = advance && (filter_done || item.last_byte);
    push.b = advance && filter_done && item.last_byte;
    res_a  = filter_done ? res_f : res_v;
    res_b  = res_v;

    if (item.last_byte) begin
      phase_next        = PH_ID_HI;
      error_code_next   = ST_OK;
      id_high_byte_next = 8'h00;
      packet_ident_next = 16'h0000;
      bytes_left_next   = 16'h0000;
      cur_len_next      = 16'h0000;
      filters_seen_next = 16'h0000;
    end else begin
      phase_next        = ph_w;
      error_code_next   = err_w;
      id_high_byte_next = idh_w;
      packet_ident_next = pid_w;
      bytes_left_next   = left_w;
      cur_len_next      = len_w;
      filters_seen_next = cnt_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_ID_HI;
      error_code   <= ST_OK;
      id_high_byte <= 8'h00;
      packet_ident <= 16'h0000;
      bytes_left   <= 16'h0000;
      cur_len      <= 16'h0000;
      filters_seen <= 16'h0000;
    end else if (advance) begin
      phase        <= phase_next;
      error_code   <= error_code_next;
      id_high_byte <= id_high_byte_next;
      packet_ident <= packet_ident_next;
      bytes_left   <= bytes_left_next;
      cur_len      <= cur_len_next;
      filters_seen <= filters_seen_next;
    end
  end

endmodule

FILE: sv/msv_out_fifo.sv
`timescale 1ns / 1ps

module msv_out_fifo import msv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  input  res_t  res_a,
  input  res_t  res_b,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  head
);

  res_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, wr_ptr_next;
  logic [FIFO_AW-1:0] rd_ptr, rd_ptr_next;
  logic [FIFO_CW-1:0] count, count_next;
  logic               pop;

  // Two free slots are needed since one beat can raise two results.
  assign room      = count <= FIFO_CW'(FIFO_DEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign head      = entries[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr + FIFO_AW'(push.a) + FIFO_AW'(push.b);
    rd_ptr_next = rd_ptr + FIFO_AW'(pop);
    count_next  = count + FIFO_CW'(push.a) + FIFO_CW'(push.b) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.a) begin
      entries[wr_ptr] <= res_a;
    end
    if (push.b) begin
      entries[wr_ptr + FIFO_AW'(1)] <= res_b;
    end
  end

endmodule

FILE: sv/mqtt_subscribe_validator.sv
`timescale 1ns / 1ps
// MQTT SUBSCRIBE body checker.
// Input channel (in_valid/in_ready): one beat per body byte after the fixed
// header. first_byte opens a packet and samples header_flags; last_byte
// closes it. has_data = 0 marks a beat with no byte (empty body).
// Output channel (out_valid/out_ready): a filter report (result_kind 0) for
// every topic filter with a legal QoS, and one verdict (result_kind 1) on
// the closing beat. last_result marks the final result caused by a beat.
// Each accepted beat waits in the input register, and its results are then
// written to the result queue, from which the receiver takes them.
// Throughput: one input beat per cycle while two queue slots are free;
// the output side moves one result per cycle; a beat closing a filter and
// the packet together raises two. The 4-entry result queue sets the slack.
// Reset clears the parse state and empties the queue; the block then
// expects the first byte of a packet.
// When the receiver stalls, results wait in the queue; once fewer than two
// slots are free the parse stage holds, the input register fills and
// in_ready drops.
module mqtt_subscribe_validator import msv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  header_flags,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic        has_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [3:0]  status,
  output logic [15:0] packet_id,
  output logic [15:0] filter_count,
  output logic [15:0] filter_length,
  output logic [1:0]  max_qos,
  output logic        last_result
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  room;
  logic  advance;
  push_t push;
  res_t  res_a;
  res_t  res_b;
  res_t  head;

  assign in_item = '{data_byte:    data_byte,
                     header_flags: header_flags,
                     first_byte:   first_byte,
                     last_byte:    last_byte,
                     has_data:     has_data};

  assign advance = item_valid && room;

  msv_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  msv_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .push    (push),
    .res_a   (res_a),
    .res_b   (res_b)
  );

  msv_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign result_kind   = head.result_kind;
  assign status        = head.status;
  assign packet_id     = head.packet_id;
  assign filter_count  = head.filter_count;
  assign filter_length = head.filter_length;
  assign max_qos       = head.max_qos;
  assign last_result   = head.last_result;

endmodule

FILE: sv/msv_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module msv_checker import msv_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  data_byte,
  input logic [3:0]  header_flags,
  input logic        first_byte,
  input logic        last_byte,
  input logic        has_data,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [3:0]  status,
  input logic [15:0] packet_id,
  input logic [15:0] filter_count,
  input logic [15:0] filter_length,
  input logic [1:0]  max_qos,
  input logic        last_result
);

  logic stall;
  logic verdict_beat;
  logic filter_beat;

  assign stall        = out_valid && !out_ready;
  assign verdict_beat = out_valid && result_kind == KIND_VERDICT;
  assign filter_beat  = out_valid && result_kind == KIND_FILTER;

  // Queue is empty right after reset.
  `MSV_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

  // A stalled result stays valid and keeps its status and packet id.
  `MSV_ASSERT(a_out_hold, stall |=> out_valid && $stable(status) && $stable(packet_id))

  // A verdict always closes the results of its beat and carries no filter.
  `MSV_ASSERT(a_verdict_last, verdict_beat |-> last_result && filter_length == '0 && max_qos == '0)

  // A filter report is always ok, with a legal QoS.
  `MSV_ASSERT(a_filter_ok, filter_beat |-> status == ST_OK && max_qos != 2'b11)

  // A filter report has a nonzero length and is counted.
  `MSV_ASSERT(a_filter_len, filter_beat |-> filter_length != '0 && filter_count != '0)

endmodule

bind mqtt_subscribe_validator msv_checker u_msv_checker (.*);

FILE: dv/subscribe_checker.sv
`timescale 1ns / 1ps

module subscribe_checker import msv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  header_flags,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic        has_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        result_kind,
  input  logic [3:0]  status,
  input  logic [15:0] packet_id,
  input  logic [15:0] filter_count,
  input  logic [15:0] filter_length,
  input  logic [1:0]  max_qos,
  input  logic        last_result,
  output int          fail_count,
  output int          pending
);

  phase_t      ph;
  logic [3:0]  err;
  logic [7:0]  id_hi;
  logic [15:0] pid;
  logic [15:0] left;
  logic [15:0] flen;
  logic [15:0] nfilt;
  res_t        expected_results[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic void clear_parse();
    ph = PH_ID_HI;
    err = ST_OK;
    id_hi = '0;
    pid = '0;
    left = '0;
    flen = '0;
    nfilt = '0;
  endfunction

  function automatic void push_result(logic kind, logic [3:0] st, logic [15:0] len,
                                      logic [1:0] qos);
    res_t r;
    r.result_kind = kind;
    r.status = st;
    r.packet_id = pid;
    r.filter_count = nfilt;
    r.filter_length = len;
    r.max_qos = qos;
    r.last_result = 1'b0;
    expected_results.push_back(r);
  endfunction

  function automatic void parse_beat(item_t b);
    int produced;
    logic [3:0] st;
    produced = 0;
    if (b.first_byte) begin
      // a new opening beat drops whatever packet was in progress
      clear_parse();
      if (b.header_flags != SUBSCRIBE_FLAGS) err = ST_FLAGS;
    end
    if (b.has_data && err == ST_OK) begin
      case (ph)
        PH_ID_HI: begin
          id_hi = b.data_byte;
          ph = PH_ID_LO;
        end
        PH_ID_LO: begin
          pid = {id_hi, b.data_byte};
          if (pid == 16'd0) err = ST_ZERO_ID;
          ph = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          flen = {b.data_byte, 8'h00};
          ph = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          flen[7:0] = b.data_byte;
          if (flen == 16'd0) begin
            err = ST_EMPTY;
          end else begin
            left = flen;
            ph = PH_FILTER;
          end
        end
        PH_FILTER: begin
          left = left - 16'd1;
          if (left == 16'd0) ph = PH_QOS;
        end
        PH_QOS: begin
          if (b.data_byte > QOS_MAX) begin
            err = ST_BAD_QOS;
          end else begin
            if (nfilt != 16'hFFFF) nfilt = nfilt + 16'd1;
            push_result(KIND_FILTER, ST_OK, flen, b.data_byte[1:0]);
            produced++;
            ph = PH_LEN_HI;
          end
        end
        default: ph = PH_ID_HI;
      endcase
    end
    if (b.last_byte) begin
      if (err != ST_OK) begin
        st = err;
      end else begin
        case (ph)
          PH_ID_HI, PH_ID_LO: st = ST_SHORT;
          PH_LEN_HI: st = (nfilt == 16'd0) ? ST_NO_FILT : ST_OK;
          PH_QOS: st = ST_NO_QOS;
          default: st = ST_TRUNC;
        endcase
      end
      push_result(KIND_VERDICT, st, '0, '0);
      produced++;
      clear_parse();
    end
    if (produced > 0) expected_results[expected_results.size() - 1].last_result = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : observe
    res_t want;
    if (rst) begin
      clear_parse();
      expected_results.delete();
    end else begin
      // results lag their beats through registers; retire before predicting
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual kind %0d status %0d",
                   $time, result_kind, status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 16'(want.result_kind), 16'(result_kind));
          check_field("status", 16'(want.status), 16'(status));
          check_field("packet_id", want.packet_id, packet_id);
          check_field("filter_count", want.filter_count, filter_count);
          check_field("filter_length", want.filter_length, filter_length);
          check_field("max_qos", 16'(want.max_qos), 16'(max_qos));
          check_field("last_result", 16'(want.last_result), 16'(last_result));
        end
      end
      if (in_valid && in_ready)
        parse_beat({data_byte, header_flags, first_byte, last_byte, has_data});
    end
    pending <= expected_results.size();
  end

endmodule

FILE: dv/mqtt_subscribe_validator_test.sv
`timescale 1ns / 1ps

module mqtt_subscribe_validator_test import msv_pkg::*; ();

  localparam int RANDOM_BEATS = 750;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 80;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic [3:0]  header_flags;
  logic        first_byte;
  logic        last_byte;
  logic        has_data;
  logic        out_valid;
  logic        out_ready;
  logic        result_kind;
  logic [3:0]  status;
  logic [15:0] packet_id;
  logic [15:0] filter_count;
  logic [15:0] filter_length;
  logic [1:0]  max_qos;
  logic        last_result;
  int          fail_count;
  int          pending;

  int          beats_sent = 0;
  bit          hold_done = 1'b0;
  logic [7:0]  body_q[$];
  item_t       packet_q[$];

  mqtt_subscribe_validator DUT (.*);

  subscribe_checker watch (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic item_t beat(logic [7:0] b, bit present);
    item_t it;
    it.data_byte = b;
    it.header_flags = 4'($urandom_range(0, 15));
    it.first_byte = 1'b0;
    it.last_byte = 1'b0;
    it.has_data = present;
    return it;
  endfunction

  task automatic send_beat(input item_t it, input bit gaps);
    int r;
    int idle;
    idle = 0;
    if (gaps) begin
      r = $urandom_range(0, 99);
      idle = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(4, 24);
    end
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    {data_byte, header_flags, first_byte, last_byte, has_data} <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Turn body_q into beats; an empty body becomes one beat with no byte.
  task automatic frame(input logic [3:0] flags, input bit opening, input bit closing);
    packet_q.delete();
    foreach (body_q[i]) packet_q.push_back(beat(body_q[i], 1'b1));
    if (packet_q.size() == 0)
      packet_q.push_back(beat(8'($urandom), 1'b0));
    else if ($urandom_range(0, 5) == 0)
      packet_q.insert($urandom_range(1, packet_q.size()), beat(8'($urandom), 1'b0));
    packet_q[0].first_byte = opening;
    if (opening) packet_q[0].header_flags = flags;
    packet_q[packet_q.size() - 1].last_byte = closing;
  endtask

  task automatic send_packet();
    bit quiet;
    quiet = ($urandom_range(0, 4) == 0);
    foreach (packet_q[i]) send_beat(packet_q[i], !quiet);
  endtask

  task automatic make_packet();
    int mode;
    int nf;
    int len;
    int qos;
    logic [15:0] id;
    logic [3:0] flags;
    item_t junk;
    body_q.delete();
    mode = $urandom_range(0, 99);
    if (mode < 6) begin
      // noise: random beats with random marks
      packet_q.delete();
      repeat ($urandom_range(1, 6)) begin
        junk.data_byte = 8'($urandom);
        junk.header_flags = 4'($urandom);
        junk.has_data = 1'($urandom);
        junk.first_byte = ($urandom_range(0, 7) == 0);
        junk.last_byte = ($urandom_range(0, 7) == 0);
        packet_q.push_back(junk);
      end
    end else begin
      id = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535));
      if (mode < 12) id = 16'h0000;
      body_q.push_back(id[15:8]);
      body_q.push_back(id[7:0]);
      if (mode >= 12 && mode < 18) begin
        // any declared length, cut off a few bytes in
        body_q.push_back(8'($urandom));
        body_q.push_back(8'($urandom));
        repeat ($urandom_range(0, 5)) body_q.push_back(8'($urandom));
      end else begin
        nf = (mode >= 18 && mode < 24) ? 0 : $urandom_range(1, 3);
        for (int f = 0; f < nf; f++) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 5);
          if (mode >= 24 && mode < 30 && f == nf - 1) len = 0;
          qos = $urandom_range(0, QOS_MAX);
          if (mode >= 30 && mode < 37 && f == nf - 1) qos = $urandom_range(QOS_MAX + 1, 255);
          body_q.push_back(len[15:8]);
          body_q.push_back(len[7:0]);
          repeat (len) body_q.push_back(8'($urandom));
          body_q.push_back(qos[7:0]);
        end
      end
      if (mode >= 37 && mode < 49)
        repeat ($urandom_range(1, body_q.size())) void'(body_q.pop_back());
      flags = SUBSCRIBE_FLAGS;
      if (mode >= 49 && mode < 55)
        while (flags == SUBSCRIBE_FLAGS) flags = 4'($urandom_range(0, 15));
      frame(flags, !(mode >= 55 && mode < 59), !(mode >= 59 && mode < 63));
    end
  endtask

  initial begin : stimulus
    int directed;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    header_flags = '0;
    first_byte = 1'b0;
    last_byte = 1'b0;
    has_data = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty body
    body_q.delete();
    frame(SUBSCRIBE_FLAGS, 1'b1, 1'b1);
    send_packet();
    // wrong flag nibbles at both extremes
    body_q = '{8'hAB};
    frame(4'h0, 1'b1, 1'b1);
    send_packet();
    body_q = '{8'h00};
    frame(4'hF, 1'b1, 1'b1);
    send_packet();
    // largest id, one filter closing together with the packet
    body_q = '{8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF, 8'h02};
    frame(SUBSCRIBE_FLAGS, 1'b1, 1'b1);
    send_packet();
    body_q = '{8'h00, 8'h00};
    frame(SUBSCRIBE_FLAGS, 1'b1, 1'b1);
    send_packet();
    body_q = '{8'h00, 8'h01};
    frame(SUBSCRIBE_FLAGS, 1'b1, 1'b1);
    send_packet();
    body_q = '{8'h12, 8'h34, 8'h00, 8'h00};
    frame(SUBSCRIBE_FLAGS, 1'b1, 1'b1);
    send_packet();
    body_q = '{8'h00, 8'h80, 8'h00, 8'h02, 8'h41, 8'h42, 8'hFF};
    frame(SUBSCRIBE_FLAGS, 1'b1, 1'b1);
    send_packet();
    directed = beats_sent;

    while (beats_sent < directed + RANDOM_BEATS) begin
      make_packet();
      send_packet();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : receiver
    int r;
    bit lvl;
    int dur;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && beats_sent >= HOLD_AFTER) begin
        // hold off long enough for the result queue to back up into in_ready
        lvl = 1'b0;
        dur = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          lvl = 1'b1;
          dur = $urandom_range(1, 8);
        end else if (r < 62) begin
          lvl = 1'b1;
          dur = 40;
        end else if (r < 90) begin
          lvl = 1'b0;
          dur = $urandom_range(1, 3);
        end else begin
          lvl = 1'b0;
          dur = $urandom_range(4, 25);
        end
      end
      out_ready <= lvl;
      repeat (dur) @(posedge clk);
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
